FILE: rtl/ws281x_pixel_bit_encoder_defines.svh
// Assertion macros shared by the pixel encoder RTL.
`ifndef WS281X_PIXEL_BIT_ENCODER_DEFINES_SVH
`define WS281X_PIXEL_BIT_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WSPBE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pixel encoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define WSPBE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pixel encoder: next-cycle check failed");

`endif

FILE: rtl/wspbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wspbe_pkg;

   // One input item: a pixel as three intensity bytes.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // One result item: three encoded channel words in output order.
   typedef struct packed {
      logic [31:0] first_word;
      logic [31:0] second_word;
      logic [31:0] third_word;
   } words_type;

   // Control shared by the scaling lanes.
   typedef struct packed {
      logic       advance;
      logic [7:0] percent;
   } lane_ctrl_type;

   // Channel orders; codes six and seven fall back to RGB.
   typedef enum logic [2:0] {
      ORDER_RGB = 3'd0,
      ORDER_BGR = 3'd1,
      ORDER_BRG = 3'd2,
      ORDER_GBR = 3'd3,
      ORDER_GRB = 3'd4,
      ORDER_RBG = 3'd5
   } order_type;

   // Register indexes on the write port.
   localparam logic CSR_COLOR_ORDER   = 1'b0;
   localparam logic CSR_POWER_PERCENT = 1'b1;

   localparam logic [7:0] FULL_SCALE      = 8'd100;
   localparam logic [7:0] RESET_PERCENT   = 8'd100;
   localparam logic [3:0] CODE_ONE        = 4'b1100;
   localparam logic [3:0] CODE_ZERO       = 4'b1000;

   // x / 100 equals (x * 5243) >> 19 for every x below 43690.
   localparam logic [12:0] RECIP_100      = 13'd5243;
   localparam int          RECIP_SHIFT    = 19;

endpackage

`default_nettype wire

FILE: rtl/ws281x_pixel_bit_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel    | Ports                              | Direction
// request    | req_valid, req_stall, req_data     | pixel items in
// response   | rsp_valid, rsp_stall, rsp_data     | encoded word items out
// register   | csr_we, csr_index, csr_wdata       | configuration writes
//
// One pixel is accepted per cycle unless the response is stalled; each item passes through
// the two multiplier stages of its lane and then the output register.
// Reset is synchronous and clears the valid bits and the configuration registers to their defaults.
// A stalled response freezes the whole pipeline, and req_stall follows it in the same cycle.

`include "ws281x_pixel_bit_encoder_defines.svh"

module ws281x_pixel_bit_encoder
   import wspbe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire pixel_type  req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output words_type       rsp_data,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);

   logic [2:0]    order_ff;
   logic [7:0]    percent_ff;
   logic          v1_ff, v2_ff, rsp_valid_ff;
   words_type     rsp_data_ff;
   words_type     merged;
   lane_ctrl_type ctrl;
   logic          advance;
   logic [7:0]    red_s, green_s, blue_s;

   // The pipeline moves whenever the output register is free or being taken.
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign ctrl.advance = advance;
   assign ctrl.percent = percent_ff;
   assign req_stall    = !advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff   <= ORDER_RGB;
         percent_ff <= RESET_PERCENT;
      end else if (csr_we) begin
         if (csr_index == CSR_COLOR_ORDER) begin
            order_ff <= csr_wdata[2:0];
         end else begin
            percent_ff <= csr_wdata;
         end
      end
   end

   // One scaling lane per color channel.
   wspbe_scale_lane u_lane_red (
      .clock   (clock),
      .ctrl    (ctrl),
      .channel (req_data.red),
      .scaled  (red_s)
   );

   wspbe_scale_lane u_lane_green (
      .clock   (clock),
      .ctrl    (ctrl),
      .channel (req_data.green),
      .scaled  (green_s)
   );

   wspbe_scale_lane u_lane_blue (
      .clock   (clock),
      .ctrl    (ctrl),
      .channel (req_data.blue),
      .scaled  (blue_s)
   );

   // Reorder and expand the lane results.
   wspbe_merge u_merge (
      .color_order (order_ff),
      .red         (red_s),
      .green       (green_s),
      .blue        (blue_s),
      .words       (merged)
   );

   // Valid bits that follow the items through the lanes.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= merged;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `WSPBE_ASSERT_IMP(a_stall_only_backpressure, clock, reset, req_stall, rsp_valid && rsp_stall)
   `WSPBE_ASSERT_NEXT(a_accept_fills_first, clock, reset, req_valid && !req_stall, v1_ff)
   `WSPBE_ASSERT_NEXT(a_first_to_second, clock, reset, v1_ff && advance, v2_ff)
   `WSPBE_ASSERT_NEXT(a_second_to_output, clock, reset, v2_ff && advance, rsp_valid)
   `WSPBE_ASSERT_NEXT(a_held_while_stalled, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

`default_nettype wire

FILE: rtl/wspbe_scale_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module wspbe_scale_lane
   import wspbe_pkg::*;
(
   input  wire logic          clock,
   input  wire lane_ctrl_type ctrl,
   input  wire logic [7:0]    channel,
   output logic [7:0]         scaled
);

   logic [15:0] prod_ff, prod_in;
   logic [7:0]  raw_ff, raw_in;
   logic [7:0]  scaled_ff, scaled_in;
   logic [28:0] quot_full;

   // First stage: channel times percent.
   always_comb begin
      prod_in = channel * ctrl.percent;
      raw_in  = channel;
   end

   // Second stage: divide by one hundred through the reciprocal, or bypass.
   always_comb begin
      quot_full = prod_ff * RECIP_100;
      if (ctrl.percent < FULL_SCALE) begin
         scaled_in = quot_full[RECIP_SHIFT +: 8];
      end else begin
         scaled_in = raw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         prod_ff   <= prod_in;
         raw_ff    <= raw_in;
         scaled_ff <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

`default_nettype wire

FILE: rtl/wspbe_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module wspbe_merge
   import wspbe_pkg::*;
(
   input  wire logic [2:0] color_order,
   input  wire logic [7:0] red,
   input  wire logic [7:0] green,
   input  wire logic [7:0] blue,
   output words_type       words
);

   logic [7:0] c0, c1, c2;

   // Bit i of the byte becomes nibble i of the word.
   function automatic logic [31:0] expand_byte(input logic [7:0] b);
      logic [31:0] w;
      w = '0;
      for (int i = 0; i < 8; i++) begin
         w[4*i +: 4] = b[i] ? CODE_ONE : CODE_ZERO;
      end
      return w;
   endfunction

   // Put the lane results into the configured channel order.
   always_comb begin
      case (order_type'(color_order))
         ORDER_BGR: begin c0 = blue;  c1 = green; c2 = red;   end
         ORDER_BRG: begin c0 = blue;  c1 = red;   c2 = green; end
         ORDER_GBR: begin c0 = green; c1 = blue;  c2 = red;   end
         ORDER_GRB: begin c0 = green; c1 = red;   c2 = blue;  end
         ORDER_RBG: begin c0 = red;   c1 = blue;  c2 = green; end
         default:   begin c0 = red;   c1 = green; c2 = blue;  end
      endcase
   end

   // Expand each ordered byte into its serializer word.
   always_comb begin
      words.first_word  = expand_byte(c0);
      words.second_word = expand_byte(c1);
      words.third_word  = expand_byte(c2);
   end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import wspbe_pkg::*;

   // Tracks the register settings and the encoded words each accepted pixel should produce.
   class pixel_word_checker;
      logic [2:0] color_sel;
      logic [7:0] percent;
      words_type  expected_words[$];
      int         errors;

      function new();
         color_sel = ORDER_RGB;
         percent   = RESET_PERCENT;
         errors    = 0;
      endfunction

      function void set_register(logic index, logic [7:0] value);
         if (index == CSR_COLOR_ORDER) begin
            color_sel = value[2:0];
         end else begin
            percent = value;
         end
      endfunction

      // Brightness scaling truncates; percents of 100 and above pass the byte through.
      function logic [7:0] dim_channel(logic [7:0] level);
         int product;
         if (percent >= FULL_SCALE) begin
            return level;
         end
         product = int'(level) * int'(percent);
         return 8'(product / 100);
      endfunction

      // Bit i of the byte becomes nibble i of the word.
      function logic [31:0] spread_bits(logic [7:0] level);
         logic [31:0] word;
         word = '0;
         for (int i = 0; i < 8; i++) begin
            word[4*i +: 4] = level[i] ? CODE_ONE : CODE_ZERO;
         end
         return word;
      endfunction

      function void note_pixel(pixel_type pixel);
         logic [7:0] r, g, b;
         logic [7:0] c0, c1, c2;
         words_type  words;
         r = dim_channel(pixel.red);
         g = dim_channel(pixel.green);
         b = dim_channel(pixel.blue);
         // Codes six and seven are unused and fall back to RGB.
         case (color_sel)
            ORDER_BGR: begin
               c0 = b; c1 = g; c2 = r;
            end
            ORDER_BRG: begin
               c0 = b; c1 = r; c2 = g;
            end
            ORDER_GBR: begin
               c0 = g; c1 = b; c2 = r;
            end
            ORDER_GRB: begin
               c0 = g; c1 = r; c2 = b;
            end
            ORDER_RBG: begin
               c0 = r; c1 = b; c2 = g;
            end
            default: begin
               c0 = r; c1 = g; c2 = b;
            end
         endcase
         words.first_word  = spread_bits(c0);
         words.second_word = spread_bits(c1);
         words.third_word  = spread_bits(c2);
         expected_words.push_back(words);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            errors++;
         end
      endfunction

      function void check_words(words_type got);
         words_type want;
         if (expected_words.size() == 0) begin
            $error("unexpected item: %h %h %h", got.first_word, got.second_word,
                   got.third_word);
            errors++;
            return;
         end
         want = expected_words.pop_front();
         compare_field("first_word", want.first_word, got.first_word);
         compare_field("second_word", want.second_word, got.second_word);
         compare_field("third_word", want.third_word, got.third_word);
      endfunction

      function int outstanding();
         return expected_words.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   pixel_type  req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   words_type  rsp_data;
   logic       csr_we = 1'b0;
   logic       csr_index = CSR_COLOR_ORDER;
   logic [7:0] csr_wdata = '0;

   pixel_word_checker book = new();
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   ws281x_pixel_bit_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Offers one pixel after an optional gap and returns at the falling edge after acceptance.
   task automatic send_pixel(input pixel_type pixel);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pixel;
      do @(posedge clock); while (req_stall);
      book.note_pixel(pixel);
      @(negedge clock);
   endtask

   // Drains the pipeline so that register writes never overlap an item in flight.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (book.outstanding() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // One write strobe, then csr_we is held low before returning so back-to-back writes never collide.
   task automatic write_csr(input logic index, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      book.set_register(index, value);
      @(negedge clock);
   endtask

   // Upper data bits are junk for the order register; only the low three count.
   task automatic set_order(input logic [2:0] order);
      logic [4:0] junk;
      junk = 5'($urandom);
      write_csr(CSR_COLOR_ORDER, {junk, order});
   endtask

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_percent();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd99;
         2: return 8'd100;
         3: return 8'($urandom_range(101, 255));
         default: return 8'($urandom_range(0, 99));
      endcase
   endfunction

   // Result side: random stall runs per item, or none while rsp_calm is set.
   initial begin
      int gap;
      while (reset) @(negedge clock);
      forever begin
         gap = rsp_calm ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         book.check_words(rsp_data);
         @(negedge clock);
      end
   end

   // Stimulus: directed corners first, then randomized phases with fresh settings.
   initial begin
      pixel_type  pixel;
      logic [7:0] fixed_percent[4] = '{8'd0, 8'd255, 8'd99, 8'd1};
      logic [7:0] percent_list[6] = '{8'd0, 8'd1, 8'd99, 8'd100, 8'd101, 8'd255};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register values straight out of reset.
      send_pixel('{red: 8'h00, green: 8'h00, blue: 8'h00});
      send_pixel('{red: 8'hff, green: 8'hff, blue: 8'hff});
      send_pixel('{red: 8'ha5, green: 8'h5a, blue: 8'h3c});
      wait_idle();

      // Every channel order, including the two unused codes.
      for (int order = 0; order < 8; order++) begin
         set_order(3'(order));
         send_pixel('{red: 8'h01, green: 8'h80, blue: 8'h5a});
         wait_idle();
      end

      // Brightness around the full-scale boundary and at both ends.
      set_order(ORDER_RGB);
      foreach (percent_list[i]) begin
         write_csr(CSR_POWER_PERCENT, percent_list[i]);
         send_pixel('{red: 8'hff, green: 8'h80, blue: 8'h01});
         wait_idle();
      end

      for (int phase = 0; phase < 14; phase++) begin
         set_order(3'(phase % 8));
         write_csr(CSR_POWER_PERCENT, (phase < 4) ? fixed_percent[phase] : pick_percent());
         req_calm = (phase % 4 == 1) || (phase % 4 == 3);
         rsp_calm = (phase % 4 == 2) || (phase % 4 == 3);
         for (int n = 0; n < 125; n++) begin
            pixel.red   = pick_channel();
            pixel.green = pick_channel();
            pixel.blue  = pick_channel();
            send_pixel(pixel);
         end
         wait_idle();
      end

      rsp_calm = 1'b0;
      repeat (20) @(negedge clock);
      if (book.errors == 0 && book.outstanding() == 0) begin
         $display("** ws281x_pixel_bit_encoder: PASSED **");
      end else begin
         $display("** ws281x_pixel_bit_encoder: FAILED **");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("** ws281x_pixel_bit_encoder: FAILED **");
      $finish;
   end

endmodule
